@@ src/cwfc_pkg.sv @@
// Shared types, widths and codes for the cost-grid window clearance checker.
package cwfc_pkg;

    // Grid store size defaults
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Field widths
    localparam int COORD_W    = 8;   // cell column / row
    localparam int COST_W     = 8;   // cell cost
    localparam int DIM_W      = 9;   // map width / height
    localparam int RAD_W      = 7;   // window half width
    localparam int CFG_IDX_W  = 3;   // register index
    localparam int CFG_DATA_W = 9;   // widest register
    localparam int SPAN_W     = 11;  // signed window bound
    localparam int CNT_W      = 9;   // scan column / row counter

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH    = 3'd0,
        REG_MAP_HEIGHT   = 3'd1,
        REG_CLEAR_RADIUS = 3'd2,
        REG_UNKNOWN_CODE = 3'd3,
        REG_FREE_CODE    = 3'd4
    } cfg_idx_t;

    // Register reset values
    localparam logic [DIM_W-1:0]  RST_MAP_WIDTH    = 9'd256;
    localparam logic [DIM_W-1:0]  RST_MAP_HEIGHT   = 9'd256;
    localparam logic [RAD_W-1:0]  RST_CLEAR_RADIUS = 7'd15;
    localparam logic [COST_W-1:0] RST_UNKNOWN_CODE = 8'd255;
    localparam logic [COST_W-1:0] RST_FREE_CODE    = 8'd0;

    // Settings seen by the scanner (map size already clipped to the store)
    typedef struct packed {
        logic [DIM_W-1:0]  used_w;
        logic [DIM_W-1:0]  used_h;
        logic [RAD_W-1:0]  radius;
        logic [COST_W-1:0] unknown_code;
        logic [COST_W-1:0] free_code;
    } scan_cfg_t;

    // Query start toward the scanner
    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } scan_req_t;

    // Scanner status and result
    typedef struct packed {
        logic idle;
        logic valid;
        logic is_clear;
    } scan_res_t;

endpackage

@@ src/cwfc_if.sv @@
// Channel interfaces: configuration writes, input items and result items.
interface cwfc_cfg_if;
    import cwfc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface cwfc_in_if;
    import cwfc_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
    logic [COST_W-1:0]  cell_cost;

    modport source (output valid, output command, output cell_col, output cell_row,
                    output cell_cost, input ready);
    modport sink   (input valid, input command, input cell_col, input cell_row,
                    input cell_cost, output ready);
endinterface

interface cwfc_out_if;
    logic valid;
    logic ready;
    logic is_clear;

    modport source (output valid, output is_clear, input ready);
    modport sink   (input valid, input is_clear, output ready);
endinterface

@@ src/cwfc_grid_mem.sv @@
// Cost grid store: one write port, one read port with registered read data.
module cwfc_grid_mem #(
    parameter int DEPTH  = cwfc_pkg::DEF_MAX_WIDTH * cwfc_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [cwfc_pkg::COST_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [cwfc_pkg::COST_W-1:0] rd_data
);
    import cwfc_pkg::*;

    logic [COST_W-1:0] mem [DEPTH];
    logic [COST_W-1:0] rd_data_reg;

    // Store one cell cost
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one cell cost, available the next cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/cwfc_scan.sv @@
// Window scanner: clips the window to the map, walks it one read a cycle, checks costs.
module cwfc_scan #(
    parameter int MAX_WIDTH  = cwfc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cwfc_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cwfc_pkg::scan_cfg_t         cfg,
    input  cwfc_pkg::scan_req_t         req,
    input  logic                        out_free,
    output cwfc_pkg::scan_res_t         res,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [cwfc_pkg::COST_W-1:0] rd_data
);
    import cwfc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  x_reg;
    logic [CNT_W-1:0]  y_reg;
    logic [CNT_W-1:0]  x_hi_reg;
    logic [CNT_W-1:0]  y_lo_reg;
    logic [CNT_W-1:0]  y_hi_reg;
    logic              pend_reg;
    logic              clear_reg;
    logic              res_valid_reg;

    logic signed [SPAN_W-1:0] x_lo_s;
    logic signed [SPAN_W-1:0] x_hi_s;
    logic signed [SPAN_W-1:0] y_lo_s;
    logic signed [SPAN_W-1:0] y_hi_s;
    logic signed [SPAN_W-1:0] w_m1_s;
    logic signed [SPAN_W-1:0] h_m1_s;
    logic signed [SPAN_W-1:0] x_lo_c;
    logic signed [SPAN_W-1:0] x_hi_c;
    logic signed [SPAN_W-1:0] y_lo_c;
    logic signed [SPAN_W-1:0] y_hi_c;
    logic                     empty;
    logic                     blocked;
    logic                     last_y;
    logic                     last_x;

    // Window bounds from the centre and radius, clipped to the map in use
    always_comb
    begin
        x_lo_s = $signed({3'b000, req.col}) - $signed({4'b0000, cfg.radius});
        y_lo_s = $signed({3'b000, req.row}) - $signed({4'b0000, cfg.radius});
        x_hi_s = $signed({3'b000, req.col}) + $signed({4'b0000, cfg.radius})
                 - 11'sd1;
        y_hi_s = $signed({3'b000, req.row}) + $signed({4'b0000, cfg.radius})
                 - 11'sd1;
        w_m1_s = $signed({2'b00, cfg.used_w}) - 11'sd1;
        h_m1_s = $signed({2'b00, cfg.used_h}) - 11'sd1;
        x_lo_c = (x_lo_s < 11'sd0) ? 11'sd0 : x_lo_s;
        y_lo_c = (y_lo_s < 11'sd0) ? 11'sd0 : y_lo_s;
        x_hi_c = (x_hi_s > w_m1_s) ? w_m1_s : x_hi_s;
        y_hi_c = (y_hi_s > h_m1_s) ? h_m1_s : y_hi_s;
        // zero radius or zero map size also lands here
        empty  = (x_lo_c > x_hi_c) || (y_lo_c > y_hi_c);
    end

    // Cost check on the data read last cycle
    assign blocked = pend_reg && (rd_data != cfg.unknown_code)
                     && (rd_data != cfg.free_code);

    assign last_y = (y_reg == y_hi_reg);
    assign last_x = (x_reg == x_hi_reg);

    // Issue one read per scan cycle
    assign rd_en   = (state_reg == S_SCAN);
    assign rd_addr = ADDR_W'(y_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_reg);

    // Sequence one query
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            clear_reg     <= 1'b1;
            x_reg         <= '0;
            y_reg         <= '0;
            x_hi_reg      <= '0;
            y_lo_reg      <= '0;
            y_hi_reg      <= '0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        x_hi_reg <= x_hi_c[CNT_W-1:0];
                        y_lo_reg <= y_lo_c[CNT_W-1:0];
                        y_hi_reg <= y_hi_c[CNT_W-1:0];
                        x_reg    <= x_lo_c[CNT_W-1:0];
                        y_reg    <= y_lo_c[CNT_W-1:0];
                        if (empty)
                        begin
                            clear_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (blocked)
                    begin
                        // stop early on the first blocking cell
                        clear_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        if (last_y)
                        begin
                            y_reg <= y_lo_reg;
                            if (last_x)
                            begin
                                state_reg <= S_DRAIN;
                            end
                            else
                            begin
                                x_reg <= x_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            y_reg <= y_reg + 1'b1;
                        end
                    end
                end
                S_DRAIN:
                begin
                    // check the last cell read
                    clear_reg <= !blocked;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.idle     = (state_reg == S_IDLE);
    assign res.valid    = res_valid_reg;
    assign res.is_clear = clear_reg;

endmodule

@@ src/costmap_window_free_check_unit.sv @@
// Top level of the cost-grid window clearance checker.
//
//   channel | role | moves
//   --------+------+------------------------------------------------------
//   cfg     | sink | register writes: index, data (always ready)
//   item    | sink | command, cell_col, cell_row, cell_cost
//   result  | src  | is_clear, one per query item, none per write item
//
// A write item inside the map goes straight to the store. A query item reads one grid
// cell per cycle from the single read port of the grid store; it ends early at the
// first blocking cell, and an empty window reads no cell.
// Reset clears control and the registers to their reset values; the grid
// store is not cleared. A waiting result does not stop write items; a query
// that finishes while a result still waits holds until the output frees.
module costmap_window_free_check_unit #(
    parameter int MAX_WIDTH  = cwfc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cwfc_pkg::DEF_MAX_HEIGHT
) (
    input  logic       clk,
    input  logic       rst_n,
    cwfc_cfg_if.sink   cfg,
    cwfc_in_if.sink    item,
    cwfc_out_if.source result
);
    import cwfc_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [DIM_W-1:0]  map_width_reg;
    logic [DIM_W-1:0]  map_height_reg;
    logic [RAD_W-1:0]  clear_radius_reg;
    logic [COST_W-1:0] unknown_code_reg;
    logic [COST_W-1:0] free_code_reg;

    scan_cfg_t         scan_cfg;
    scan_req_t         scan_req;
    scan_res_t         scan_res;
    logic              item_acc;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [COST_W-1:0] rd_data;
    logic              out_free;
    logic              out_valid_reg;
    logic              out_clear_reg;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= RST_MAP_WIDTH;
            map_height_reg   <= RST_MAP_HEIGHT;
            clear_radius_reg <= RST_CLEAR_RADIUS;
            unknown_code_reg <= RST_UNKNOWN_CODE;
            free_code_reg    <= RST_FREE_CODE;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_MAP_WIDTH:    map_width_reg    <= cfg.data[DIM_W-1:0];
                REG_MAP_HEIGHT:   map_height_reg   <= cfg.data[DIM_W-1:0];
                REG_CLEAR_RADIUS: clear_radius_reg <= cfg.data[RAD_W-1:0];
                REG_UNKNOWN_CODE: unknown_code_reg <= cfg.data[COST_W-1:0];
                REG_FREE_CODE:    free_code_reg    <= cfg.data[COST_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clip the map size to the store
    always_comb
    begin
        scan_cfg.used_w = (int'(map_width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH)
                                                              : map_width_reg;
        scan_cfg.used_h = (int'(map_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT)
                                                                : map_height_reg;
        scan_cfg.radius       = clear_radius_reg;
        scan_cfg.unknown_code = unknown_code_reg;
        scan_cfg.free_code    = free_code_reg;
    end

    // Accept items while the scanner is idle
    assign item.ready = scan_res.idle;
    assign item_acc   = item.valid && scan_res.idle;

    // Write items inside the map go straight to the store
    assign wr_en   = item_acc && (item.command == CMD_WRITE)
                     && ({1'b0, item.cell_col} < scan_cfg.used_w)
                     && ({1'b0, item.cell_row} < scan_cfg.used_h);
    assign wr_addr = ADDR_W'(item.cell_row) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(item.cell_col);

    // Query items start the scanner
    assign scan_req.start = item_acc && (item.command == CMD_QUERY);
    assign scan_req.col   = item.cell_col;
    assign scan_req.row   = item.cell_row;

    cwfc_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_grid (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.cell_cost),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cwfc_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (scan_cfg),
        .req      (scan_req),
        .out_free (out_free),
        .res      (scan_res),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // Hold the result until taken
    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (scan_res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_res.valid)
        begin
            out_clear_reg <= scan_res.is_clear;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.is_clear = out_clear_reg;

endmodule

@@ src/cwfc_checker.sv @@
// Port-level assertions for the window clearance checker, bound to the top level.
module cwfc_checker (
    input logic clk,
    input logic rst_n,
    input logic cfg_ready,
    input logic item_valid,
    input logic item_ready,
    input logic item_command,
    input logic result_valid,
    input logic result_ready,
    input logic result_is_clear
);
    import cwfc_pkg::*;

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_is_clear))
        else $error("result dropped or changed while stalled");

    // Register writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

    // Block new items while a query scans
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_command == CMD_QUERY) |=> !item_ready)
        else $error("item taken during a query scan");

    // A new result follows a busy cycle
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready, 2))
        else $error("result appeared without a query scan");

endmodule

bind costmap_window_free_check_unit cwfc_checker u_cwfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_ready       (cfg.ready),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_command    (item.command),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_is_clear (result.is_clear)
);
